// ===== rtl/priority_two_resource_allocator_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef PRIORITY_TWO_RESOURCE_ALLOCATOR_MACROS_SVH
`define PRIORITY_TWO_RESOURCE_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PTRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PTRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTRA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/ptra_pkg.sv =====
`timescale 1ns / 1ps

package ptra_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam logic KIND_REQ = 1'b0;
    localparam logic KIND_REL = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_IDLE    = 3'd2,
        ST_FULL    = 3'd3,
        ST_BADREL  = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the incoming transfer
        logic exec;   // apply the captured item and register its result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } t_sts;

endpackage

// ===== rtl/ptra_ctrl.sv =====
`timescale 1ns / 1ps

module ptra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ptra_pkg::t_sts  i_sts,
    output ptra_pkg::t_ctl  o_ctl
);
    import ptra_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_ctl.load = i_in_valid && (r_state == S_IDLE);
    assign o_ctl.exec = (r_state == S_EXEC) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/ptra_datapath.sv =====
`timescale 1ns / 1ps

module ptra_datapath #(
    parameter int QUEUE_DEPTH   = ptra_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = ptra_pkg::PRIORITY_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptra_pkg::t_ctl  i_ctl,
    output ptra_pkg::t_sts  o_sts,
    input  logic            i_kind,
    input  logic [7:0]      i_tag,
    input  logic [7:0]      i_prio,
    input  logic            i_res,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [2:0]      o_status,
    output logic            o_grant_valid,
    output logic [7:0]      o_grant_tag,
    output logic            o_grant_resource,
    output logic [4:0]      o_waiting_count
);
    import ptra_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // captured item
    logic                     r_kind;
    logic [7:0]               r_tag;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic                     r_res;

    // allocator state; queue kept sorted by priority, stable in arrival order
    logic [1:0]               r_free;
    logic [1:0]               n_free;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [7:0]               r_wtag  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] r_wprio [QUEUE_DEPTH];

    // result register
    logic                     r_out_valid;
    t_status                  r_status;
    logic                     r_gvalid;
    logic [7:0]               r_gtag;
    logic                     r_gres;

    t_status                  w_status;
    logic                     w_gvalid;
    logic [7:0]               w_gtag;
    logic                     w_gres;
    logic                     w_ins;
    logic                     w_pop;
    logic                     w_full;
    logic [QUEUE_DEPTH-1:0]   w_ge;
    logic [QUEUE_DEPTH-1:0]   w_prev_ge;

    assign w_full = (r_count == CNT_W'(QUEUE_DEPTH));

    // slot holds an entry that stays ahead of a new arrival
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ge[i] = (CNT_W'(i) < r_count) && (r_wprio[i] >= r_prio);
        end
    end

    always_comb begin
        n_free   = r_free;
        n_count  = r_count;
        w_status = ST_FULL;
        w_gvalid = 1'b0;
        w_gtag   = 8'd0;
        w_gres   = 1'b0;
        w_ins    = 1'b0;
        w_pop    = 1'b0;
        if (r_kind == KIND_REQ) begin
            priority if (r_count == '0 && r_free != 2'b00) begin
                w_status         = ST_GRANTED;
                w_gvalid         = 1'b1;
                w_gtag           = r_tag;
                w_gres           = ~r_free[0];
                n_free[~r_free[0]] = 1'b0;
            end else if (!w_full) begin
                w_status = ST_QUEUED;
                w_ins    = 1'b1;
                n_count  = r_count + CNT_W'(1);
            end else begin
                w_status = ST_FULL;
            end
        end else begin
            priority if (r_free[r_res]) begin
                w_status = ST_BADREL;
            end else if (r_count == '0) begin
                w_status      = ST_IDLE;
                n_free[r_res] = 1'b1;
            end else begin
                // head of the sorted queue takes the released resource
                w_status = ST_GRANTED;
                w_gvalid = 1'b1;
                w_gtag   = r_wtag[0];
                w_gres   = r_res;
                w_pop    = 1'b1;
                n_count  = r_count - CNT_W'(1);
            end
        end
    end

    // one shift-chain cell per queue slot
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        logic [7:0]               w_ptag;
        logic [PRIORITY_BITS-1:0] w_pprio;
        logic [7:0]               w_ntag;
        logic [PRIORITY_BITS-1:0] w_nprio;

        if (g == 0) begin : g_first
            assign w_prev_ge[g] = 1'b1;
            assign w_ptag       = r_tag;
            assign w_pprio      = r_prio;
        end else begin : g_mid
            assign w_prev_ge[g] = w_ge[g-1];
            assign w_ptag       = r_wtag[g-1];
            assign w_pprio      = r_wprio[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_ntag  = r_wtag[g];
            assign w_nprio = r_wprio[g];
        end else begin : g_inner
            assign w_ntag  = r_wtag[g+1];
            assign w_nprio = r_wprio[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.exec) begin
                if (w_ins && !w_ge[g]) begin
                    if (w_prev_ge[g]) begin
                        r_wtag[g]  <= r_tag;
                        r_wprio[g] <= r_prio;
                    end else begin
                        r_wtag[g]  <= w_ptag;
                        r_wprio[g] <= w_pprio;
                    end
                end else if (w_pop) begin
                    r_wtag[g]  <= w_ntag;
                    r_wprio[g] <= w_nprio;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_kind <= i_kind;
            r_tag  <= i_tag;
            r_prio <= PRIORITY_BITS'(i_prio);
            r_res  <= i_res;
        end
        if (i_ctl.exec) begin
            r_status <= w_status;
            r_gvalid <= w_gvalid;
            r_gtag   <= w_gtag;
            r_gres   <= w_gres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= 2'b11;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                r_free  <= n_free;
                r_count <= n_count;
            end
            if (i_ctl.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_grant_valid     = r_gvalid;
    assign o_grant_tag       = r_gtag;
    assign o_grant_resource  = r_gres;
    assign o_waiting_count   = 5'(r_count);

endmodule

// ===== rtl/priority_two_resource_allocator.sv =====
`timescale 1ns / 1ps
// Two-resource allocator with a priority wait queue. Each input transfer is a
// request (tuser 0) or a release (tuser 1) and yields exactly one result
// transfer. A request is granted at once (lowest-numbered free resource) when
// nobody waits; otherwise it joins a queue of QUEUE_DEPTH entries, or is
// rejected with "queue full". A release hands the resource to the waiting
// request of highest priority, earliest arrival first among equals; with no
// waiters it frees the resource, and a release of a free resource is flagged.
// A transfer is captured first; then the queue is updated and the result
// register loaded, waiting while the result register stays occupied
// downstream, and no new transfer is taken until then. The queue is a shift
// chain kept in priority order, so an insert and a removal both finish in the
// update step regardless of depth. No clearing pass is needed after reset.
module priority_two_resource_allocator #(
    parameter int QUEUE_DEPTH   = ptra_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = ptra_pkg::PRIORITY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] requester_tag, [15:8] priority_req,
                                        // [16] resource, [23:17] zero
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] grant_tag, [8] grant_resource,
                                        // [13:9] waiting_count, [15:14] zero
    output logic [3:0]  m_axis_tuser    // [2:0] status, [3] grant_valid
);
    import ptra_pkg::*;

    `include "priority_two_resource_allocator_macros.svh"

    t_ctl       w_ctl;
    t_sts       w_sts;
    logic [2:0] w_status;
    logic       w_gvalid;
    logic [7:0] w_gtag;
    logic       w_gres;
    logic [4:0] w_wcount;

    // sequencing: capture, then execute once the result register is free
    ptra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // resource map, sorted wait queue and result register
    ptra_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_kind           (s_axis_tuser[0]),
        .i_tag            (s_axis_tdata[7:0]),
        .i_prio           (s_axis_tdata[15:8]),
        .i_res            (s_axis_tdata[16]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_status         (w_status),
        .o_grant_valid    (w_gvalid),
        .o_grant_tag      (w_gtag),
        .o_grant_resource (w_gres),
        .o_waiting_count  (w_wcount)
    );

    assign m_axis_tdata = {2'b00, w_wcount, w_gres, w_gtag};
    assign m_axis_tuser = {w_gvalid, w_status};

    // after a transfer is taken the block is busy for at least the update cycle
    `PTRA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready stayed high after an accepted transfer")
    // a new result only appears after an execute cycle
    `PTRA_ASSERT(a_result_from_exec, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(w_ctl.exec), "result appeared without an execute cycle")
    // the grant flag goes with the granted status and nothing else
    `PTRA_ASSERT(a_grant_matches_status, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser[3] == (m_axis_tuser[2:0] == ST_GRANTED)), "grant flag disagrees with status")
    // reported queue occupancy never exceeds the queue size
    `PTRA_ASSERT(a_count_in_range, i_clk, i_rst_n, m_axis_tvalid |-> (int'(m_axis_tdata[13:9]) <= QUEUE_DEPTH), "waiting count above queue depth")

endmodule
